@@ rtl/hyd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the hydrometer advert decoder.
// No dependencies; every other file imports this package.
package hyd_pkg;

   localparam int DecodeBytes = 24;

   localparam logic [2:0] StOk       = 3'd0;
   localparam logic [2:0] StShort    = 3'd1;
   localparam logic [2:0] StHeader   = 3'd2;
   localparam logic [2:0] StUuid     = 3'd3;
   localparam logic [2:0] StRange    = 3'd4;
   localparam logic [2:0] StModeNone = 3'd5;

   localparam logic [1:0] ModeNone   = 2'd0;
   localparam logic [1:0] ModeBeacon = 2'd1;
   localparam logic [1:0] ModeRapt   = 2'd2;
   localparam logic [1:0] ModeBoth   = 2'd3;

   localparam logic [2:0] RegScanMode   = 3'd0;
   localparam logic [2:0] RegGravityMin = 3'd1;
   localparam logic [2:0] RegGravityMax = 3'd2;
   localparam logic [2:0] RegTempMin    = 3'd3;
   localparam logic [2:0] RegTempMax    = 3'd4;

   localparam logic [7:0] UuidBase [16] = '{
      8'hA4, 8'h95, 8'hBB, 8'h00, 8'hC5, 8'hB1, 8'h4B, 8'h44,
      8'hB5, 8'h12, 8'h13, 8'h70, 8'hF0, 8'h2D, 8'h74, 8'hDE};

   // Reciprocal constants for an exact truncating divide by nine, scaled by 2^24.
   localparam logic [63:0] Mul500Full = ((64'd500 << 24) + 64'd8) / 64'd9;
   localparam logic [63:0] Mul50Full  = ((64'd50 << 24) + 64'd8) / 64'd9;
   localparam logic [29:0] Mul500 = Mul500Full[29:0];
   localparam logic [29:0] Mul50  = Mul50Full[29:0];

   typedef logic [DecodeBytes-1:0][7:0] rec_type;

   typedef struct packed {
      logic       done;
      logic [7:0] len;
   } cap_type;

   typedef struct packed {
      logic [15:0]        gmin;
      logic [15:0]        gmax;
      logic signed [15:0] tmin;
      logic signed [15:0] tmax;
   } lim_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               format_kind;
      logic [2:0]         color_index;
      logic               pro_model;
      logic [15:0]        gravity_e4;
      logic signed [15:0] temp_centi_c;
      logic [15:0]        battery_raw;
      logic               velocity_valid;
      logic [31:0]        velocity_bits;
      logic [7:0]         format_version;
   } res_type;

   function automatic logic range_bad(input logic [15:0] g, input logic [15:0] t,
                                      input logic clip, input lim_type lim);
      range_bad = clip || (g < lim.gmin) || (g > lim.gmax) ||
                  ($signed(t) < $signed(lim.tmin)) || ($signed(t) > $signed(lim.tmax));
   endfunction

endpackage

@@ rtl/hydrometer_advert_decoder.sv @@
`timescale 1ns / 1ps
// Top level of the hydrometer advert decoder: register port, capture, both decoders, result
// register. Depends on hyd_pkg, hyd_capture, hyd_beacon and hyd_rapt.
//
// The block takes one byte of a manufacturer-data record per beat and gives one result beat
// per record, registered after the last-byte beat has set the capture done flag. A byte
// is taken in every cycle; the input stalls only while a finished record waits for decoding
// and the result register still holds a result that the far side has not taken. Decoding
// is a single pass of logic between the captured bytes and the result register.
module hydrometer_advert_decoder import hyd_pkg::*; #(
   parameter int CAPTURE_BYTES = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic               rsp_format_kind,
   output logic [2:0]         rsp_color_index,
   output logic               rsp_pro_model,
   output logic [15:0]        rsp_gravity_e4,
   output logic signed [15:0] rsp_temp_centi_c,
   output logic [15:0]        rsp_battery_raw,
   output logic               rsp_velocity_valid,
   output logic [31:0]        rsp_velocity_bits,
   output logic [7:0]         rsp_format_version,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [1:0] scan_mode_ff;
   lim_type    lim_ff;
   logic       wr;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_mode_ff <= ModeNone;
         lim_ff.gmin  <= 16'd9900;
         lim_ff.gmax  <= 16'd12000;
         lim_ff.tmin  <= -16'sd1000;
         lim_ff.tmax  <= 16'sd5000;
      end else if (wr) begin
         unique case (idx)
            RegScanMode:   scan_mode_ff <= csr_pwdata[1:0];
            RegGravityMin: lim_ff.gmin  <= csr_pwdata[15:0];
            RegGravityMax: lim_ff.gmax  <= csr_pwdata[15:0];
            RegTempMin:    lim_ff.tmin  <= csr_pwdata[15:0];
            RegTempMax:    lim_ff.tmax  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         RegScanMode:   csr_prdata = {30'd0, scan_mode_ff};
         RegGravityMin: csr_prdata = {16'd0, lim_ff.gmin};
         RegGravityMax: csr_prdata = {16'd0, lim_ff.gmax};
         RegTempMin:    csr_prdata = {16'd0, lim_ff.tmin};
         RegTempMax:    csr_prdata = {16'd0, lim_ff.tmax};
         default:       csr_prdata = 32'd0;
      endcase
   end

   rec_type rec;
   cap_type cap;
   logic    take, advance, out_valid_ff, out_valid_in;
   res_type beacon_res, rapt_res, sel_res, res_ff;

   assign advance   = cap.done && (!out_valid_ff || !rsp_stall);
   assign req_stall = cap.done && !advance;
   assign take      = req_valid && !req_stall;

   hyd_capture #(.CaptureBytes(CAPTURE_BYTES)) u_capture (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .advance   (advance),
      .rec       (rec),
      .cap       (cap)
   );

   hyd_beacon u_beacon (.rec(rec), .len(cap.len), .lim(lim_ff), .res(beacon_res));
   hyd_rapt   u_rapt   (.rec(rec), .len(cap.len), .lim(lim_ff), .res(rapt_res));

   always_comb begin
      sel_res = '0;
      unique case (scan_mode_ff)
         ModeBeacon: sel_res = beacon_res;
         ModeRapt:   sel_res = rapt_res;
         ModeBoth: begin
            if (beacon_res.status == StOk) begin
               sel_res = beacon_res;
            end else if (rapt_res.status == StOk || rapt_res.status == StRange) begin
               sel_res = rapt_res;
            end else begin
               sel_res = beacon_res;
            end
         end
         default: sel_res.status = StModeNone;
      endcase
   end

   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= sel_res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = res_ff.status;
   assign rsp_format_kind    = res_ff.format_kind;
   assign rsp_color_index    = res_ff.color_index;
   assign rsp_pro_model      = res_ff.pro_model;
   assign rsp_gravity_e4     = res_ff.gravity_e4;
   assign rsp_temp_centi_c   = res_ff.temp_centi_c;
   assign rsp_battery_raw    = res_ff.battery_raw;
   assign rsp_velocity_valid = res_ff.velocity_valid;
   assign rsp_velocity_bits  = res_ff.velocity_bits;
   assign rsp_format_version = res_ff.format_version;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the result register could drain");

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != StOk && rsp_status != StRange) |->
      (rsp_gravity_e4 == 16'd0 && rsp_temp_centi_c == 16'sd0 && rsp_format_version == 8'd0))
      else $error("failed decode carries nonzero values");

   a_velocity_gated: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_velocity_valid) |-> (rsp_velocity_bits == 32'd0))
      else $error("velocity bits without valid velocity");

endmodule

@@ rtl/hyd_capture.sv @@
`timescale 1ns / 1ps
// Byte capture for one record: byte counter, captured bytes and the record-done flag.
// Depends on hyd_pkg.
module hyd_capture import hyd_pkg::*; #(
   parameter int CaptureBytes = 25
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  logic       advance,
   output rec_type    rec,
   output cap_type    cap
);

   localparam int IdxBits = $clog2(CaptureBytes);

   logic [7:0] record_ff [CaptureBytes];
   logic [7:0] count_ff, count_in, count_inc;
   cap_type    cap_ff, cap_in;

   assign count_inc = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;

   always_comb begin
      count_in = count_ff;
      cap_in   = cap_ff;
      if (advance) begin
         cap_in.done = 1'b0;
      end
      if (take) begin
         count_in = last_byte ? 8'd0 : count_inc;
         if (last_byte) begin
            cap_in.done = 1'b1;
            cap_in.len  = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 8'd0;
         cap_ff   <= '0;
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && (count_ff < 8'(CaptureBytes))) begin
         record_ff[count_ff[IdxBits-1:0]] <= data_byte;
      end
   end

   always_comb begin
      for (int i = 0; i < DecodeBytes; i++) begin
         rec[i] = record_ff[i];
      end
   end

   assign cap = cap_ff;

endmodule

@@ rtl/hyd_beacon.sv @@
`timescale 1ns / 1ps
// Beacon-format decoder: header and UUID checks, fixed-point temperature and gravity.
// Depends on hyd_pkg.
module hyd_beacon import hyd_pkg::*; (
   input  rec_type     rec,
   input  logic [7:0]  len,
   input  lim_type     lim,
   output res_type     res
);

   logic        hdr_ok, uuid_ok, pro, clip, neg;
   logic [3:0]  hi;
   logic [15:0] traw, graw, gval, tval;
   logic [12:0] mag;
   logic [29:0] mul;
   logic [42:0] prod;
   logic [14:0] quo;

   always_comb begin
      hdr_ok = (rec[0] == 8'h4C) && (rec[1] == 8'h00) && (rec[2] == 8'h02) &&
               (rec[3] == 8'h15);
      uuid_ok = 1'b1;
      for (int k = 0; k < 16; k++) begin
         if (k != 3 && rec[4 + k] != UuidBase[k]) begin
            uuid_ok = 1'b0;
         end
      end
      hi = rec[7][7:4];
      if (rec[7][3:0] != 4'd0 || hi < 4'd1 || hi > 4'd8) begin
         uuid_ok = 1'b0;
      end

      traw = {rec[20], rec[21]};
      graw = {rec[22], rec[23]};
      pro  = graw > 16'd5000;
      if (pro) begin
         clip = traw > 16'd6218;
         neg  = traw < 16'd320;
         mag  = neg ? 13'(16'd320 - traw) : 13'(traw - 16'd320);
         mul  = Mul50;
         gval = graw;
      end else begin
         clip = traw > 16'd621;
         neg  = traw < 16'd32;
         mag  = neg ? 13'(16'd32 - traw) : 13'(traw - 16'd32);
         mul  = Mul500;
         gval = 16'(graw * 16'd10);
      end
      prod = 43'(mag) * 43'(mul);
      quo  = prod[38:24];
      if (clip) begin
         tval = 16'h7FFF;
      end else if (neg) begin
         tval = 16'(-{1'b0, quo});
      end else begin
         tval = {1'b0, quo};
      end

      res = '0;
      if (len < 8'd25) begin
         res.status = StShort;
      end else if (!hdr_ok) begin
         res.status = StHeader;
      end else if (!uuid_ok) begin
         res.status = StUuid;
      end else begin
         res.color_index    = 3'(hi - 4'd1);
         res.pro_model      = pro;
         res.gravity_e4     = gval;
         res.temp_centi_c   = tval;
         res.format_version = pro ? 8'd2 : 8'd1;
         res.status         = range_bad(gval, tval, clip, lim) ? StRange : StOk;
      end
   end

endmodule

@@ rtl/hyd_rapt.sv @@
`timescale 1ns / 1ps
// RAPT-format decoder: header check, kelvin temperature and float gravity to fixed point.
// Depends on hyd_pkg.
module hyd_rapt import hyd_pkg::*; (
   input  rec_type     rec,
   input  logic [7:0]  len,
   input  lim_type     lim,
   output res_type     res
);

   logic               hdr_ok, vv, clip, fneg, tneg;
   logic [15:0]        traw, gval, tval;
   logic [22:0]        scaled;
   logic signed [24:0] tdiff;
   logic [24:0]        tmag;
   logic [31:0]        fbits;
   logic [7:0]         ex, shamt;
   logic [22:0]        fr;
   logic [27:0]        t10, q;

   always_comb begin
      hdr_ok = (rec[0] == 8'h52) && (rec[1] == 8'h41) && (rec[2] == 8'h50) &&
               (rec[3] == 8'h54);
      vv = rec[6] == 8'h01;

      traw   = {rec[11], rec[12]};
      scaled = 23'(traw) * 23'd100;
      tdiff  = $signed({2'b00, scaled}) - 25'sd3496320;
      tneg   = tdiff < 25'sd0;
      tmag   = tneg ? 25'(-tdiff) : 25'(tdiff);
      tval   = tneg ? 16'(-tmag[22:7]) : tmag[22:7];

      fbits = {rec[13], rec[14], rec[15], rec[16]};
      fneg  = fbits[31];
      ex    = fbits[30:23];
      fr    = fbits[22:0];
      t10   = 28'({1'b1, fr}) * 28'd10;
      shamt = 8'd150 - ex;
      q     = t10 >> shamt[4:0];
      clip  = 1'b0;
      gval  = 16'd0;
      if (ex == 8'hFF) begin
         clip = 1'b1;
         gval = (fr == 23'd0 && !fneg) ? 16'hFFFF : 16'd0;
      end else if (ex <= 8'd122) begin
         gval = 16'd0;
      end else if (ex >= 8'd150) begin
         clip = 1'b1;
         gval = fneg ? 16'd0 : 16'hFFFF;
      end else if (q == 28'd0) begin
         gval = 16'd0;
      end else if (fneg) begin
         clip = 1'b1;
      end else if (q > 28'd65535) begin
         clip = 1'b1;
         gval = 16'hFFFF;
      end else begin
         gval = q[15:0];
      end

      res = '0;
      res.format_kind = 1'b1;
      if (len < 8'd24) begin
         res.status = StShort;
      end else if (!hdr_ok) begin
         res.status = StHeader;
      end else begin
         res.format_version = rec[6];
         res.velocity_valid = vv;
         res.velocity_bits  = vv ? {rec[7], rec[8], rec[9], rec[10]} : 32'd0;
         res.temp_centi_c   = tval;
         res.gravity_e4     = gval;
         res.battery_raw    = {rec[23], rec[22]};
         res.status         = range_bad(gval, tval, clip, lim) ? StRange : StOk;
      end
   end

endmodule

@@ bench/tb_hydrometer_advert_decoder.sv @@
`timescale 1ns / 1ps
// Self-checking bench for hydrometer_advert_decoder: drives advert records byte by byte and
// compares every result beat with a predictor of its own. Depends on hyd_pkg and the RTL.
module tb_hydrometer_advert_decoder;
   import hyd_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_beat_type;

   localparam int CycleLimit = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_format_kind;
   logic [2:0]  rsp_color_index;
   logic        rsp_pro_model;
   logic [15:0] rsp_gravity_e4;
   logic signed [15:0] rsp_temp_centi_c;
   logic [15:0] rsp_battery_raw;
   logic        rsp_velocity_valid;
   logic [31:0] rsp_velocity_bits;
   logic [7:0]  rsp_format_version;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   byte_beat_type pending_bytes[$];
   res_type     expected_results[$];
   logic [7:0]  record_build[$];
   logic [7:0]  seen_bytes[25];
   logic [7:0]  seen_count = '0;
   logic [1:0]  mode_copy = ModeNone;
   logic [15:0] gmin_copy = 16'd9900;
   logic [15:0] gmax_copy = 16'd12000;
   logic signed [15:0] tmin_copy = -16'sd1000;
   logic signed [15:0] tmax_copy = 16'sd5000;
   bit          no_gaps = 1'b0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          bytes_sent = 0;
   int          records_sent = 0;

   hydrometer_advert_decoder uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] sat_centi(longint v, output bit clip);
      clip = 1'b0;
      if (v > 32767) begin clip = 1'b1; return 16'h7FFF; end
      if (v < -32768) begin clip = 1'b1; return 16'h8000; end
      return v[15:0];
   endfunction

   function automatic logic [15:0] gravity_from_float(logic [31:0] b, output bit clip);
      logic [7:0] ex;
      longint unsigned m, t;
      int e;
      clip = 1'b0;
      ex = b[30:23];
      if (ex == 8'hFF) begin
         clip = 1'b1;
         return (b[22:0] == 0 && !b[31]) ? 16'hFFFF : 16'h0000;
      end
      if (ex == 0) begin m = 64'(b[22:0]); e = -149; end
      else begin m = 64'({1'b1, b[22:0]}); e = int'(ex) - 150; end
      t = m * 10;
      if (e >= 0) begin
         if (t != 0 && e > 20) t = 64'h10000;
         else t = t << e;
      end else t = (-e >= 64) ? 64'd0 : (t >> (-e));
      if (t == 0) return 16'h0000;
      if (b[31]) begin clip = 1'b1; return 16'h0000; end
      if (t > 65535) begin clip = 1'b1; return 16'hFFFF; end
      return t[15:0];
   endfunction

   function automatic logic [2:0] limits_status(longint g, logic [15:0] t, bit clip);
      if (clip || g < gmin_copy || g > gmax_copy || $signed(t) < tmin_copy ||
          $signed(t) > tmax_copy) return StRange;
      return StOk;
   endfunction

   function automatic res_type decode_beacon(int len);
      res_type r;
      logic [15:0] traw, graw;
      logic [3:0] hue;
      longint t, g;
      bit clip;
      r = '0;
      if (len < 25) begin r.status = StShort; return r; end
      if (seen_bytes[0] != 8'h4C || seen_bytes[1] != 8'h00 || seen_bytes[2] != 8'h02 ||
          seen_bytes[3] != 8'h15) begin
         r.status = StHeader;
         return r;
      end
      for (int k = 0; k < 16; k++)
         if (k != 3 && seen_bytes[4 + k] != UuidBase[k]) begin
            r.status = StUuid;
            return r;
         end
      hue = seen_bytes[7][7:4];
      if (seen_bytes[7][3:0] != 0 || hue < 1 || hue > 8) begin
         r.status = StUuid;
         return r;
      end
      traw = {seen_bytes[20], seen_bytes[21]};
      graw = {seen_bytes[22], seen_bytes[23]};
      r.pro_model = graw > 5000;
      if (r.pro_model) begin
         t = (longint'(traw) - 320) * 50 / 9;
         g = graw;
      end else begin
         t = (longint'(traw) - 32) * 500 / 9;
         g = longint'(graw) * 10;
      end
      r.temp_centi_c = sat_centi(t, clip);
      r.color_index = 3'(hue - 4'd1);
      r.gravity_e4 = g[15:0];
      r.format_version = r.pro_model ? 8'd2 : 8'd1;
      r.status = limits_status(g, r.temp_centi_c, clip);
      return r;
   endfunction

   function automatic res_type decode_rapt(int len);
      res_type r;
      longint t;
      bit tclip, gclip;
      r = '0;
      r.format_kind = 1'b1;
      if (len < 24) begin r.status = StShort; return r; end
      if (seen_bytes[0] != 8'h52 || seen_bytes[1] != 8'h41 || seen_bytes[2] != 8'h50 ||
          seen_bytes[3] != 8'h54) begin
         r.status = StHeader;
         return r;
      end
      r.format_version = seen_bytes[6];
      if (seen_bytes[6] == 8'h01) begin
         r.velocity_valid = 1'b1;
         r.velocity_bits = {seen_bytes[7], seen_bytes[8], seen_bytes[9], seen_bytes[10]};
      end
      t = (longint'({seen_bytes[11], seen_bytes[12]}) * 100 - 3496320) / 128;
      r.temp_centi_c = sat_centi(t, tclip);
      r.gravity_e4 = gravity_from_float({seen_bytes[13], seen_bytes[14], seen_bytes[15],
                                         seen_bytes[16]}, gclip);
      r.battery_raw = {seen_bytes[23], seen_bytes[22]};
      r.status = limits_status(r.gravity_e4, r.temp_centi_c, tclip || gclip);
      return r;
   endfunction

   function automatic res_type decode_record(int len);
      res_type a, b;
      a = '0;
      case (mode_copy)
         ModeBeacon: a = decode_beacon(len);
         ModeRapt:   a = decode_rapt(len);
         ModeBoth: begin
            a = decode_beacon(len);
            if (a.status != StOk) begin
               b = decode_rapt(len);
               if (b.status == StOk || b.status == StRange) a = b;
            end
         end
         default: a.status = StModeNone;
      endcase
      return a;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_bytes.size() > 0 && (no_gaps || $urandom_range(99) >= 17)) begin
            byte_beat_type nb;
            nb = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= nb.data;
            req_last_byte <= nb.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      res_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result beat with nothing expected, status %0d", $time,
                        rsp_status);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("format_kind", want.format_kind, rsp_format_kind);
               check_field("color_index", want.color_index, rsp_color_index);
               check_field("pro_model", want.pro_model, rsp_pro_model);
               check_field("gravity_e4", want.gravity_e4, rsp_gravity_e4);
               check_field("temp_centi_c", want.temp_centi_c, rsp_temp_centi_c);
               check_field("battery_raw", want.battery_raw, rsp_battery_raw);
               check_field("velocity_valid", want.velocity_valid, rsp_velocity_valid);
               check_field("velocity_bits", want.velocity_bits, rsp_velocity_bits);
               check_field("format_version", want.format_version, rsp_format_version);
            end
         end
         if (req_valid && !req_stall) begin
            if (seen_count < 8'd25) seen_bytes[seen_count[4:0]] = req_data_byte;
            if (seen_count < 8'd255) seen_count = seen_count + 8'd1;
            if (req_last_byte) begin
               expected_results.push_back(decode_record(seen_count));
               seen_count = 8'd0;
            end
         end
         rsp_stall <= !no_gaps && ($urandom_range(99) < 17);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("hydrometer_advert_decoder test failed");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         RegScanMode:   mode_copy = value[1:0];
         RegGravityMin: gmin_copy = value[15:0];
         RegGravityMax: gmax_copy = value[15:0];
         RegTempMin:    tmin_copy = value[15:0];
         RegTempMax:    tmax_copy = value[15:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [1:0] mode, logic [15:0] gmin, logic [15:0] gmax,
                            logic [15:0] tmin, logic [15:0] tmax);
      csr_write(RegScanMode, {30'd0, mode});
      csr_write(RegGravityMin, {16'd0, gmin});
      csr_write(RegGravityMax, {16'd0, gmax});
      csr_write(RegTempMin, {16'd0, tmin});
      csr_write(RegTempMax, {16'd0, tmax});
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() > 0 || req_valid || expected_results.size() > 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_record();
      for (int i = 0; i < record_build.size(); i++)
         pending_bytes.push_back('{record_build[i], i == record_build.size() - 1});
      bytes_sent += record_build.size();
      records_sent++;
      record_build.delete();
   endtask

   task automatic add16(logic [15:0] v);
      record_build.push_back(v[15:8]);
      record_build.push_back(v[7:0]);
   endtask

   task automatic build_beacon(logic [3:0] hue, logic [15:0] traw, logic [15:0] graw);
      record_build = '{8'h4C, 8'h00, 8'h02, 8'h15};
      for (int k = 0; k < 16; k++)
         record_build.push_back(k == 3 ? {hue, 4'h0} : UuidBase[k]);
      add16(traw);
      add16(graw);
      record_build.push_back(8'($urandom_range(255)));
   endtask

   task automatic build_rapt(logic [7:0] ver, logic [31:0] vel, logic [15:0] kraw,
                             logic [31:0] gbits, logic [15:0] batt);
      record_build = '{8'h52, 8'h41, 8'h50, 8'h54, 8'($urandom_range(255)),
                       8'($urandom_range(255))};
      record_build.push_back(ver);
      add16(vel[31:16]);
      add16(vel[15:0]);
      add16(kraw);
      add16(gbits[31:16]);
      add16(gbits[15:0]);
      repeat (5) record_build.push_back(8'($urandom_range(255)));
      record_build.push_back(batt[7:0]);
      record_build.push_back(batt[15:8]);
   endtask

   task automatic build_noise(int len);
      record_build.delete();
      repeat (len) record_build.push_back(8'($urandom_range(255)));
   endtask

   function automatic logic [31:0] random_gravity_bits();
      case ($urandom_range(9))
         0: return $urandom();
         1: return 32'h7FC00000 | $urandom_range(255);
         2: return {1'($urandom_range(1)), 8'hFF, 23'h0};
         3: return {1'b0, 8'h00, 23'($urandom())};
         4: return {1'b1, 8'($urandom_range(120, 140)), 23'($urandom())};
         default: return {1'b0, 8'd137, 3'b000, 20'($urandom())};
      endcase
   endfunction

   task automatic random_record();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         if ($urandom_range(1))
            build_beacon(4'($urandom_range(1, 8)), 16'($urandom_range(32, 120)),
                         16'($urandom_range(950, 1250)));
         else if ($urandom_range(3) == 0)
            build_beacon(4'($urandom_range(1, 8)), 16'($urandom()), 16'($urandom()));
         else
            build_beacon(4'($urandom_range(1, 8)), 16'($urandom_range(300, 1200)),
                         16'($urandom_range(9500, 12500)));
      end else if (pick < 80) begin
         build_rapt($urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'($urandom_range(2)),
                    $urandom(), $urandom_range(3) == 0 ? 16'($urandom()) :
                    16'($urandom_range(34960, 39000)), random_gravity_bits(),
                    16'($urandom()));
      end else begin
         build_noise($urandom_range(1, 30));
      end
      if (pick < 80 && $urandom_range(4) == 0)
         record_build[$urandom_range(23)] = 8'($urandom_range(255));
      if (pick < 80 && $urandom_range(4) == 0)
         while (record_build.size() > 1 + $urandom_range(25)) void'(record_build.pop_back());
      if ($urandom_range(5) == 0)
         repeat ($urandom_range(1, 12)) record_build.push_back(8'($urandom_range(255)));
      send_record();
   endtask

   initial begin
      int phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      build_beacon(4'h1, 16'd68, 16'd1050);
      send_record();
      build_noise(1);
      send_record();
      wait_drained();

      configure(ModeBoth, 16'd9900, 16'd12000, -16'sd1000, 16'sd5000);
      build_beacon(4'h1, 16'd68, 16'd1050);
      send_record();
      build_beacon(4'h8, 16'd680, 16'd10500);
      send_record();
      build_beacon(4'h9, 16'd68, 16'd1050);
      send_record();
      build_beacon(4'h0, 16'd68, 16'd1050);
      send_record();
      build_beacon(4'h3, 16'hFFFF, 16'd5000);
      send_record();
      build_beacon(4'h4, 16'd0, 16'd5001);
      send_record();
      build_beacon(4'h2, 16'd70, 16'd1000);
      record_build[7] = 8'h21;
      send_record();
      build_beacon(4'h2, 16'd70, 16'd1000);
      record_build[12] = 8'h00;
      send_record();
      build_beacon(4'h5, 16'd70, 16'd1000);
      void'(record_build.pop_back());
      send_record();
      build_beacon(4'h6, 16'd70, 16'd1000);
      record_build[2] = 8'h03;
      send_record();
      build_beacon(4'h7, 16'd70, 16'd1000);
      repeat (6) record_build.push_back(8'hFF);
      send_record();
      build_rapt(8'h01, 32'h3F800000, 16'd37523, 32'h44820000, 16'h0F5C);
      send_record();
      build_rapt(8'h00, 32'hFFFFFFFF, 16'd37523, 32'h44820000, 16'hFFFF);
      send_record();
      build_rapt(8'hFF, 32'h0, 16'd0, 32'h7FC00000, 16'h0);
      send_record();
      build_rapt(8'h01, 32'h0, 16'hFFFF, 32'h7F800000, 16'h1234);
      send_record();
      build_rapt(8'h01, 32'h0, 16'd37523, 32'hFF800000, 16'h1234);
      send_record();
      build_rapt(8'h01, 32'h0, 16'd37523, 32'hC4820000, 16'h1234);
      send_record();
      build_rapt(8'h01, 32'h0, 16'd37523, 32'h00000001, 16'h1234);
      send_record();
      build_rapt(8'h01, 32'h0, 16'd37523, 32'h7F7FFFFF, 16'h1234);
      send_record();
      build_rapt(8'h02, 32'h0, 16'd37523, 32'h80000000, 16'h1234);
      void'(record_build.pop_back());
      send_record();
      build_noise(1);
      send_record();
      build_noise(300);
      send_record();
      wait_drained();

      phase = 0;
      while (phase < 8 || bytes_sent < 1100 || records_sent < 40) begin
         case (phase)
            0: configure(ModeBeacon, 16'd0, 16'hFFFF, 16'h8000, 16'h7FFF);
            1: configure(ModeRapt, 16'd0, 16'hFFFF, 16'h8000, 16'h7FFF);
            2: configure(ModeBoth, 16'd12000, 16'd9900, 16'h7FFF, 16'h8000);
            3: configure(ModeBeacon, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
            4: configure(ModeNone, 16'd0, 16'd0, 16'h8000, 16'h8000);
            5: configure(ModeBoth, 16'd9900, 16'd12000, -16'sd1000, 16'sd5000);
            default: configure(2'($urandom_range(3)), 16'($urandom_range(9000, 11000)),
                               16'($urandom_range(10500, 21000)),
                               16'($urandom_range(0, 3000) - 5000),
                               16'($urandom_range(1000, 6000)));
         endcase
         no_gaps = (phase == 6);
         repeat (phase == 6 ? 8 : 2) random_record();
         wait_drained();
         phase++;
      end
      no_gaps = 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("hydrometer_advert_decoder test passed");
      else
         $display("hydrometer_advert_decoder test failed");
      $finish;
   end

endmodule
